[rtl/core/bfc4_pkg.sv]
// Package for the 4-bit complex beamformer MAC core.
// Holds the widths, the fixed-point constants and the controller/datapath types.
// Has no dependencies of its own.
package bfc4_pkg;

  localparam int SMP_W          = 4;
  localparam int GAIN_W         = 24;
  localparam int GAIN_FRAC_BITS = 16;
  localparam int SUM_W          = 20;
  localparam int PROD_W         = SUM_W + GAIN_W;
  localparam int OUT_W          = 4;
  localparam int OUT_LIMIT      = 7;

  typedef enum logic [1:0] {
    ST_ACC,
    ST_MUL,
    ST_RND
  } state_t;

  typedef struct packed {
    logic acc;
    logic mul;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

endpackage

[rtl/core/beamformer_complex4_mac_core.sv]
// Top level of the 4-bit complex beamformer MAC core.
// Joins the controller bfc4_ctrl and the datapath bfc4_dp; uses bfc4_pkg.
//
// Usage. Each input item carries one dish's complex sample (e_re, e_im), its
// complex beam weight (a_re, a_im), a gain in unsigned Q8.16 and a last_dish
// flag. An item is accepted on a rising edge where in_valid is high and
// in_stall is low; results leave the same way on the out_ channel.
// The product a * e of every item is added to a running complex sum that
// saturates at the 20-bit signed range. Items without last_dish give no
// result and are taken one per cycle.
// On a last_dish item the sums are multiplied by that item's gain in the
// next cycle (two 20 by 24 bit multipliers); the products are rounded half
// to even and clamped to -7..7 as they are loaded into the result register,
// which the rounding step waits for until it is free. The input channel
// stalls from the last dish item until that load, and out_valid is
// registered together with the result.
// While the receiver stalls, the result register holds its item and the
// block completes its next beam up to the rounding step, then waits there.
// Reset (synchronous, rst_n low) clears the sums, empties the result
// register and returns the controller to accumulation.
module beamformer_complex4_mac_core
  import bfc4_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [SMP_W-1:0] in_e_re,
  input  logic signed [SMP_W-1:0] in_e_im,
  input  logic signed [SMP_W-1:0] in_a_re,
  input  logic signed [SMP_W-1:0] in_a_im,
  input  logic [GAIN_W-1:0]       in_gain,
  input  logic                    in_last_dish,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [OUT_W-1:0] out_j_re,
  output logic signed [OUT_W-1:0] out_j_im
);

  cmd_t    cmd;
  status_t status;

  // The controller decides when items enter and when a scaled result moves on.
  bfc4_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_last_dish (in_last_dish),
    .status       (status),
    .in_stall     (in_stall),
    .cmd          (cmd)
  );

  // The datapath holds the sums, the gain products and the result register.
  bfc4_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .in_e_re   (in_e_re),
    .in_e_im   (in_e_im),
    .in_a_re   (in_a_re),
    .in_a_im   (in_a_im),
    .in_gain   (in_gain),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_j_re  (out_j_re),
    .out_j_im  (out_j_im)
  );

endmodule

[rtl/core/bfc4_ctrl.sv]
// Controller for the 4-bit complex beamformer MAC core.
// Sequences accumulation, scaling and result hand-over; uses bfc4_pkg.
module bfc4_ctrl
  import bfc4_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  logic    in_last_dish,
  input  status_t status,
  output logic    in_stall,
  output cmd_t    cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_ACC;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_ACC: begin
        if (in_valid && in_last_dish) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        state_nxt = ST_RND;
      end
      ST_RND: begin
        if (status.out_free) begin
          state_nxt = ST_ACC;
        end
      end
      default: begin
        state_nxt = ST_ACC;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      ST_ACC: begin
        in_stall = 1'b0;
        cmd.acc  = in_valid;
      end
      ST_MUL: begin
        cmd.mul = 1'b1;
      end
      ST_RND: begin
        cmd.load = status.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

[rtl/core/bfc4_dp.sv]
// Datapath for the 4-bit complex beamformer MAC core.
// Complex MAC with saturating sums, gain multiply, rounding and output register; uses bfc4_pkg.
module bfc4_dp
  import bfc4_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  cmd_t                    cmd,
  output status_t                 status,
  input  logic signed [SMP_W-1:0] in_e_re,
  input  logic signed [SMP_W-1:0] in_e_im,
  input  logic signed [SMP_W-1:0] in_a_re,
  input  logic signed [SMP_W-1:0] in_a_im,
  input  logic [GAIN_W-1:0]       in_gain,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [OUT_W-1:0] out_j_re,
  output logic signed [OUT_W-1:0] out_j_im
);

  localparam int EXT_W = SUM_W + 2;
  localparam int PP_W  = 2 * SMP_W;
  localparam int Q_W   = PROD_W - GAIN_FRAC_BITS;
  localparam logic signed [EXT_W-1:0] SUM_MAX = EXT_W'((1 << (SUM_W - 1)) - 1);
  localparam logic signed [EXT_W-1:0] SUM_MIN = -SUM_MAX - EXT_W'(1);
  localparam logic [GAIN_FRAC_BITS-1:0] RND_HALF = {1'b1, {(GAIN_FRAC_BITS-1){1'b0}}};

  logic signed [SUM_W-1:0]  sum_re_r, sum_re_nxt;
  logic signed [SUM_W-1:0]  sum_im_r, sum_im_nxt;
  logic [GAIN_W-1:0]        gain_r;
  logic [PROD_W-1:0]        prod_re_r, prod_im_r;
  logic                     neg_re_r, neg_im_r;
  logic                     out_valid_r;
  logic signed [OUT_W-1:0]  j_re_r, j_im_r;

  logic signed [PP_W-1:0]   pp_rr, pp_ii, pp_ri, pp_ir;
  logic [SUM_W-1:0]         mag_re, mag_im;

  function automatic logic signed [SUM_W-1:0] sat_sum(input logic signed [EXT_W-1:0] v);
    logic signed [SUM_W-1:0] res;
    if (v > SUM_MAX) begin
      res = SUM_MAX[SUM_W-1:0];
    end else if (v < SUM_MIN) begin
      res = SUM_MIN[SUM_W-1:0];
    end else begin
      res = v[SUM_W-1:0];
    end
    return res;
  endfunction

  function automatic logic [EXT_W-1:0] ext_pp(input logic signed [PP_W-1:0] p);
    return {{(EXT_W-PP_W){p[PP_W-1]}}, p};
  endfunction

  // Round half to even, clamp the magnitude to the output limit, reapply the sign.
  function automatic logic signed [OUT_W-1:0] round_part(input logic [PROD_W-1:0] p,
                                                         input logic neg);
    logic [Q_W-1:0]            q;
    logic [GAIN_FRAC_BITS-1:0] r;
    logic                      inc;
    logic [OUT_W-1:0]          mag;
    q   = p[PROD_W-1:GAIN_FRAC_BITS];
    r   = p[GAIN_FRAC_BITS-1:0];
    inc = (r > RND_HALF) || ((r == RND_HALF) && q[0]);
    if (q >= Q_W'(OUT_LIMIT)) begin
      mag = OUT_W'(OUT_LIMIT);
    end else begin
      mag = q[OUT_W-1:0] + OUT_W'(inc);
    end
    return neg ? -mag : mag;
  endfunction

  assign pp_rr = in_a_re * in_e_re;
  assign pp_ii = in_a_im * in_e_im;
  assign pp_ri = in_a_re * in_e_im;
  assign pp_ir = in_a_im * in_e_re;

  always_comb begin
    sum_re_nxt = sat_sum({{2{sum_re_r[SUM_W-1]}}, sum_re_r} + ext_pp(pp_rr) - ext_pp(pp_ii));
    sum_im_nxt = sat_sum({{2{sum_im_r[SUM_W-1]}}, sum_im_r} + ext_pp(pp_ri) + ext_pp(pp_ir));
  end

  assign mag_re = sum_re_r[SUM_W-1] ? (~sum_re_r + SUM_W'(1)) : sum_re_r;
  assign mag_im = sum_im_r[SUM_W-1] ? (~sum_im_r + SUM_W'(1)) : sum_im_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_re_r <= '0;
      sum_im_r <= '0;
    end else if (cmd.acc) begin
      sum_re_r <= sum_re_nxt;
      sum_im_r <= sum_im_nxt;
    end else if (cmd.mul) begin
      sum_re_r <= '0;
      sum_im_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.acc) begin
      gain_r <= in_gain;
    end
    if (cmd.mul) begin
      prod_re_r <= PROD_W'(mag_re) * PROD_W'(gain_r);
      prod_im_r <= PROD_W'(mag_im) * PROD_W'(gain_r);
      neg_re_r  <= sum_re_r[SUM_W-1];
      neg_im_r  <= sum_im_r[SUM_W-1];
    end
    if (cmd.load) begin
      j_re_r <= round_part(prod_re_r, neg_re_r);
      j_im_r <= round_part(prod_im_r, neg_im_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign status.out_free = !out_valid_r || !out_stall;
  assign out_valid       = out_valid_r;
  assign out_j_re        = j_re_r;
  assign out_j_im        = j_im_r;

  // The result register is only loaded when its previous item has gone or is leaving.
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> (!out_valid_r || !out_stall))
    else $error("result register overwritten while its item was stalled");

  // Sums are clear once the scaling step has taken them.
  a_sum_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mul |=> (sum_re_r == '0) && (sum_im_r == '0))
    else $error("sums not cleared after scaling");

  // Saturation never produces the most negative code.
  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (j_re_r != -OUT_W'(8)) && (j_im_r != -OUT_W'(8)))
    else $error("result outside -7..7");

  // No accumulation or load while a finished sum is being scaled.
  a_no_acc_mul: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mul |-> !cmd.acc && !cmd.load)
    else $error("accumulate or load during scaling");

endmodule

[dv/tb.sv]
// Self-checking testbench for the 4-bit complex beamformer MAC core.
// Depends on bfc4_pkg and beamformer_complex4_mac_core (with bfc4_ctrl and bfc4_dp); needs nothing else.
`timescale 1ns / 100ps

module tb
  import bfc4_pkg::*;
();

  localparam int CLK_PERIOD   = 20;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 240;
  localparam int MAX_REPORTS  = 10;
  // Long beams that build up sums far beyond a single product.
  localparam int LONG_DISHES  = 60;
  localparam int LONG_BACKOFF = 10;

  // One input item: a dish sample, its beam weight, the gain and the beam marker.
  typedef struct {
    logic signed [SMP_W-1:0] e_re;
    logic signed [SMP_W-1:0] e_im;
    logic signed [SMP_W-1:0] a_re;
    logic signed [SMP_W-1:0] a_im;
    logic [GAIN_W-1:0]       gain;
    logic                    last;
  } dish_t;

  // One result item: the scaled beam output.
  typedef struct {
    logic signed [OUT_W-1:0] j_re;
    logic signed [OUT_W-1:0] j_im;
  } beam_t;

  logic                    clk = 1'b0;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  logic signed [SMP_W-1:0] in_e_re;
  logic signed [SMP_W-1:0] in_e_im;
  logic signed [SMP_W-1:0] in_a_re;
  logic signed [SMP_W-1:0] in_a_im;
  logic [GAIN_W-1:0]       in_gain;
  logic                    in_last_dish;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic signed [OUT_W-1:0] out_j_re;
  logic signed [OUT_W-1:0] out_j_im;

  beamformer_complex4_mac_core uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_e_re      (in_e_re),
    .in_e_im      (in_e_im),
    .in_a_re      (in_a_re),
    .in_a_im      (in_a_im),
    .in_gain      (in_gain),
    .in_last_dish (in_last_dish),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_j_re     (out_j_re),
    .out_j_im     (out_j_im)
  );

  // Expected beam outputs, oldest first, and the predictor's own running sums.
  beam_t beam_q[$];
  int    acc_re;
  int    acc_im;

  int err_count;
  int results_seen;
  int dishes_sent;
  int beams_sent;
  int beam_len;
  int longest_beam;
  int cycle_count;

  // Idling controls. The sender works in bursts; the receiver follows its own
  // stall pattern, whose character is chosen afresh at random.
  bit gaps_on;
  bit stalls_on;
  int burst_left;
  int stall_mode;
  int stall_phase;
  int stall_period;

  always #(CLK_PERIOD / 2) clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // The running sums stick at the 20-bit signed range instead of wrapping.
  function automatic int clamp_sum(input int v);
    int hi;
    int lo;
    hi = (1 << (SUM_W - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // Scales one sum by the unsigned fixed-point gain. The magnitude is scaled
  // and rounded half to even, so negative values mirror positive ones, and the
  // result is clamped to the output range before the sign is put back.
  function automatic logic signed [OUT_W-1:0] scale_to_output(input int s,
                                                             input logic [GAIN_W-1:0] g);
    longint unsigned mag;
    longint unsigned prod;
    longint unsigned whole;
    longint unsigned frac;
    longint unsigned half;
    int              v;
    mag   = (s < 0) ? longint'(-longint'(s)) : longint'(s);
    prod  = mag * longint'(g);
    whole = prod >> GAIN_FRAC_BITS;
    frac  = prod & ((64'd1 << GAIN_FRAC_BITS) - 64'd1);
    half  = 64'd1 << (GAIN_FRAC_BITS - 1);
    if (frac > half || (frac == half && whole[0])) whole++;
    if (whole > OUT_LIMIT) whole = OUT_LIMIT;
    v = int'(whole);
    if (s < 0) v = -v;
    return v[OUT_W-1:0];
  endfunction

  // Adds the complex product a * e of one accepted item to the sums; on the
  // last dish it works out the beam output and clears the sums.
  function automatic void predict_beam(input dish_t d);
    int    ere;
    int    eim;
    int    are;
    int    aim;
    beam_t b;
    ere = d.e_re;
    eim = d.e_im;
    are = d.a_re;
    aim = d.a_im;
    acc_re = clamp_sum(acc_re + are * ere - aim * eim);
    acc_im = clamp_sum(acc_im + are * eim + aim * ere);
    dishes_sent++;
    beam_len++;
    if (d.last) begin
      b.j_re = scale_to_output(acc_re, d.gain);
      b.j_im = scale_to_output(acc_im, d.gain);
      beam_q.push_back(b);
      acc_re = 0;
      acc_im = 0;
      beams_sent++;
      if (beam_len > longest_beam) longest_beam = beam_len;
      beam_len = 0;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic dish_t make_dish(input int ere, input int eim, input int are,
                                      input int aim, input int g, input bit last);
    dish_t d;
    d.e_re = ere[SMP_W-1:0];
    d.e_im = eim[SMP_W-1:0];
    d.a_re = are[SMP_W-1:0];
    d.a_im = aim[SMP_W-1:0];
    d.gain = g[GAIN_W-1:0];
    d.last = last;
    return d;
  endfunction

  // A quarter of the samples sit at the extremes, the rest are uniform.
  function automatic int rand_sample();
    if ($urandom_range(0, 3) == 0) return ($urandom_range(0, 1) == 0) ? -8 : 7;
    return int'($urandom_range(0, 15)) - 8;
  endfunction

  // Most gains are small enough that the outputs land inside -7..7; the rest
  // are zero, the full 24-bit range, or a power of two that produces ties.
  function automatic logic [GAIN_W-1:0] rand_gain();
    case ($urandom_range(0, 6))
      0:       return GAIN_W'($urandom());
      1:       return '0;
      2:       return GAIN_W'($urandom_range(0, 'h10000));
      3:       return GAIN_W'($urandom_range(0, 'h1000));
      4:       return GAIN_W'(1 << $urandom_range(8, 17));
      default: return GAIN_W'($urandom_range(0, 'h400));
    endcase
  endfunction

  // Sends one item and returns once it has been accepted. Valid stays high
  // afterwards, so back-to-back items need no extra edge; a gap lowers it.
  task automatic send_dish(input dish_t d);
    int gap;
    if (gaps_on) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 16);
        gap = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 30) : $urandom_range(1, 4);
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left--;
    end
    @(negedge clk);
    in_e_re      <= d.e_re;
    in_e_im      <= d.e_im;
    in_a_re      <= d.a_re;
    in_a_im      <= d.a_im;
    in_gain      <= d.gain;
    in_last_dish <= d.last;
    in_valid     <= 1'b1;
    do @(posedge clk); while (in_stall);
    predict_beam(d);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver and checker
  // ---------------------------------------------------------------------------

  // Stall pattern: none, stalled half of the time at random, one in four, or long
  // stalls broken by a free stretch in every period.
  always @(negedge clk) begin
    if (stall_phase == 0) begin
      stall_mode   = $urandom_range(0, 3);
      stall_phase  = $urandom_range(16, 128);
      stall_period = $urandom_range(3, 24);
    end
    stall_phase--;
    if (!stalls_on || stall_mode == 0) out_stall <= 1'b0;
    else if (stall_mode == 1)          out_stall <= ($urandom_range(0, 1) == 0);
    else if (stall_mode == 2)          out_stall <= ($urandom_range(0, 3) == 0);
    else                               out_stall <= (stall_phase % stall_period) >= 2;
  end

  task automatic log_error(input string msg);
    err_count++;
    if (err_count <= MAX_REPORTS) $display("%0t ns: %s", $time, msg);
  endtask

  // Every accepted result is matched against the oldest expected beam.
  always @(posedge clk) begin
    beam_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (beam_q.size() == 0) begin
        log_error($sformatf("result (%0d, %0d) with no beam outstanding",
                            out_j_re, out_j_im));
      end else begin
        want = beam_q.pop_front();
        if (out_j_re !== want.j_re)
          log_error($sformatf("beam %0d j_re: expected %0d, got %0d",
                              results_seen, want.j_re, out_j_re));
        if (out_j_im !== want.j_im)
          log_error($sformatf("beam %0d j_im: expected %0d, got %0d",
                              results_seen, want.j_im, out_j_im));
      end
      results_seen++;
    end
  end

  // Guard against a hang anywhere in the run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Extreme samples and weights, zero and full-scale gain, and a short beam
  // whose non-final items carry gains that must be ignored.
  task automatic test_extremes();
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    send_dish(make_dish(7, 7, 7, 7, 'h10000, 1'b1));
    send_dish(make_dish(-8, -8, -8, -8, 'h800, 1'b1));
    send_dish(make_dish(7, -8, -8, 7, 'hFFFFFF, 1'b1));
    send_dish(make_dish(7, 7, -8, 0, 'hFFFFFF, 1'b1));
    send_dish(make_dish(-8, 7, 7, -8, 'h0, 1'b1));
    send_dish(make_dish(0, 0, 0, 0, 'hFFFFFF, 1'b1));
    send_dish(make_dish(-8, 7, 3, -2, 'hABCDEF, 1'b0));
    send_dish(make_dish(5, -3, -8, 7, 'hFFFFFF, 1'b0));
    send_dish(make_dish(1, 2, -1, 4, 'h2000, 1'b1));
  endtask

  // Values that land exactly halfway go to the even integer, and negative
  // values round like their positive mirror images.
  task automatic test_rounding_ties();
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    send_dish(make_dish(1, -1, 1, 0, 'h8000, 1'b1));
    send_dish(make_dish(3, -3, 1, 0, 'h8000, 1'b1));
    send_dish(make_dish(5, -7, 1, 0, 'h8000, 1'b1));
    send_dish(make_dish(7, -8, 1, 0, 'h8000, 1'b1));
    send_dish(make_dish(1, -3, 1, 0, 'h18000, 1'b1));
    send_dish(make_dish(5, -1, 1, 0, 'h18000, 1'b1));
    send_dish(make_dish(2, -6, 1, 0, 'h4000, 1'b1));
    send_dish(make_dish(-6, 6, 1, 0, 'h4000, 1'b1));
  endtask

  // Long beams build up sums of several thousand, first upwards and then
  // downwards, and back off part of the way before the last dish. A small
  // gain brings the large sums back into the output range.
  task automatic test_long_beams();
    gaps_on   = 1'b0;
    stalls_on = 1'b1;
    // Real part climbs by 120 per item.
    repeat (LONG_DISHES) send_dish(make_dish(-8, 7, -8, -8, 'h0, 1'b0));
    repeat (LONG_BACKOFF) send_dish(make_dish(7, -8, -8, -8, 'h0, 1'b0));
    send_dish(make_dish(0, 0, 0, 0, 'h40, 1'b1));
    // And the same downwards.
    repeat (LONG_DISHES) send_dish(make_dish(7, -8, -8, -8, 'h0, 1'b0));
    repeat (LONG_BACKOFF) send_dish(make_dish(-8, 7, -8, -8, 'h0, 1'b0));
    send_dish(make_dish(0, 0, 0, 0, 'h40, 1'b1));
  endtask

  // Random beams, mostly short with some longer ones; the idling of both
  // sides is chosen afresh for every beam.
  task automatic test_random_beams();
    int    start;
    int    len;
    dish_t d;
    start = dishes_sent;
    while (dishes_sent - start < RANDOM_ITEMS) begin
      gaps_on   = ($urandom_range(0, 3) != 0);
      stalls_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 9) < 8) len = $urandom_range(1, 6);
      else                          len = $urandom_range(7, 40);
      for (int i = 0; i < len; i++) begin
        d = make_dish(rand_sample(), rand_sample(), rand_sample(), rand_sample(),
                      0, i == len - 1);
        // Non-final items get random gains too; the block must not use them.
        d.gain = (i == len - 1) ? rand_gain() : GAIN_W'($urandom());
        send_dish(d);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Run
  // ---------------------------------------------------------------------------

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_e_re      = '0;
    in_e_im      = '0;
    in_a_re      = '0;
    in_a_im      = '0;
    in_gain      = '0;
    in_last_dish = 1'b0;
    gaps_on      = 1'b0;
    stalls_on    = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_extremes();
    test_rounding_ties();
    test_long_beams();
    test_random_beams();

    // Drain: wait for every outstanding beam, then keep watching the output
    // so that any stray extra result is still caught.
    @(negedge clk);
    in_valid  <= 1'b0;
    stalls_on = 1'b0;
    while (beam_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Covered %0d dish items in %0d beams, longest beam %0d dishes.",
             dishes_sent, beams_sent, longest_beam);
    $display("Checked %0d beam results; %0d mismatches.", results_seen, err_count);
    if (err_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
